>>> hw/rtl/bqc_pkg.sv
// ----------------------------------------------------------------------------
// bqc_pkg
// Shared types, constants and the microcode table of the biquad cascade.
// ----------------------------------------------------------------------------
package bqc_pkg;

	localparam int MAX_SECTIONS = 3;
	localparam int SECT_W       = $clog2(MAX_SECTIONS + 1);
	localparam int SAMPLE_W     = 16;
	localparam int COEF_W       = 16;
	localparam int ACC_W        = 32;
	localparam int FRAC_BITS    = 15;
	localparam int FF_W         = 3 * COEF_W;
	localparam int FB_W         = 2 * COEF_W;
	localparam int PADDR_W      = 6;
	localparam int PDATA_W      = 64;
	localparam int STEP_W       = 3;

	typedef enum logic [2:0] {
		REG_ACTIVE = 3'd0,
		REG_FF0    = 3'd1,
		REG_FB0    = 3'd2,
		REG_FF1    = 3'd3,
		REG_FB1    = 3'd4,
		REG_FF2    = 3'd5,
		REG_FB2    = 3'd6
	} reg_idx_t;

	typedef enum logic [2:0] {
		COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2
	} coef_sel_t;

	typedef enum logic [1:0] {
		OPB_ZERO, OPB_S1, OPB_S2, OPB_P
	} opb_sel_t;

	typedef enum logic [2:0] {
		DST_NONE, DST_Y, DST_ACC, DST_S1, DST_S2
	} dst_t;

	typedef enum logic {
		SEQ_NEXT, SEQ_SECT_END
	} seq_op_t;

	typedef struct packed {
		logic      mul_en;
		coef_sel_t coef;
		logic      mul_y;
		logic      opa_acc;
		opb_sel_t  opb;
		logic      sub;
		dst_t      dst;
		seq_op_t   seq;
	} uword_t;

	typedef struct packed {
		logic                  go;
		uword_t                uw;
		logic [SECT_W-1:0]     sect;
		logic                  load_in;
		logic                  advance;
		logic                  out_load;
	} dp_ctrl_t;

	typedef struct packed {
		logic [SECT_W-1:0]                  sections;
		logic [MAX_SECTIONS-1:0][FF_W-1:0]  ff;
		logic [MAX_SECTIONS-1:0][FB_W-1:0]  fb;
	} cfg_t;

	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w = '{mul_en: 1'b0, coef: COEF_B0, mul_y: 1'b0, opa_acc: 1'b0,
		      opb: OPB_ZERO, sub: 1'b0, dst: DST_NONE, seq: SEQ_NEXT};
		case (step)
			3'd0: begin
				w.mul_en = 1'b1;
				w.coef   = COEF_B0;
			end
			3'd1: begin
				w.mul_en = 1'b1;
				w.coef   = COEF_B1;
				w.opb    = OPB_S1;
				w.dst    = DST_Y;
			end
			3'd2: begin
				w.mul_en = 1'b1;
				w.coef   = COEF_A1;
				w.mul_y  = 1'b1;
				w.opb    = OPB_S2;
				w.dst    = DST_ACC;
			end
			3'd3: begin
				w.mul_en  = 1'b1;
				w.coef    = COEF_B2;
				w.opa_acc = 1'b1;
				w.opb     = OPB_P;
				w.sub     = 1'b1;
				w.dst     = DST_S1;
			end
			3'd4: begin
				w.mul_en = 1'b1;
				w.coef   = COEF_A2;
				w.mul_y  = 1'b1;
				w.opb    = OPB_ZERO;
				w.dst    = DST_ACC;
			end
			3'd5: begin
				w.opa_acc = 1'b1;
				w.opb     = OPB_P;
				w.sub     = 1'b1;
				w.dst     = DST_S2;
				w.seq     = SEQ_SECT_END;
			end
			default: begin
				w.seq = SEQ_SECT_END;
			end
		endcase
		return w;
	endfunction

endpackage

>>> hw/rtl/bqc_if.sv
// ----------------------------------------------------------------------------
// bqc_if
// Sample request channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bqc_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in;

	modport source (output valid, output sample_in, input ready);
	modport sink (input valid, input sample_in, output ready);
endinterface

interface bqc_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out;

	modport source (output valid, output sample_out, input ready);
	modport sink (input valid, input sample_out, output ready);
endinterface

>>> hw/rtl/bqc_regs.sv
// ----------------------------------------------------------------------------
// bqc_regs
// APB configuration registers: section count and per-section coefficients.
// ----------------------------------------------------------------------------
module bqc_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bqc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bqc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bqc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	output bqc_pkg::cfg_t                cfg
);

	bqc_pkg::cfg_t    cfg_q;
	bqc_pkg::reg_idx_t idx;
	logic             wr;

	assign idx    = bqc_pkg::reg_idx_t'(paddr[bqc_pkg::PADDR_W-1:3]);
	assign wr     = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sections <= bqc_pkg::SECT_W'(2);
			cfg_q.ff       <= '0;
			cfg_q.fb       <= '0;
		end else if (wr) begin
			case (idx)
				bqc_pkg::REG_ACTIVE: cfg_q.sections <= pwdata[bqc_pkg::SECT_W-1:0];
				bqc_pkg::REG_FF0:    cfg_q.ff[0]    <= pwdata[bqc_pkg::FF_W-1:0];
				bqc_pkg::REG_FB0:    cfg_q.fb[0]    <= pwdata[bqc_pkg::FB_W-1:0];
				bqc_pkg::REG_FF1:    cfg_q.ff[1]    <= pwdata[bqc_pkg::FF_W-1:0];
				bqc_pkg::REG_FB1:    cfg_q.fb[1]    <= pwdata[bqc_pkg::FB_W-1:0];
				bqc_pkg::REG_FF2:    cfg_q.ff[2]    <= pwdata[bqc_pkg::FF_W-1:0];
				bqc_pkg::REG_FB2:    cfg_q.fb[2]    <= pwdata[bqc_pkg::FB_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			bqc_pkg::REG_ACTIVE: prdata = bqc_pkg::PDATA_W'(cfg_q.sections);
			bqc_pkg::REG_FF0:    prdata = bqc_pkg::PDATA_W'(cfg_q.ff[0]);
			bqc_pkg::REG_FB0:    prdata = bqc_pkg::PDATA_W'(cfg_q.fb[0]);
			bqc_pkg::REG_FF1:    prdata = bqc_pkg::PDATA_W'(cfg_q.ff[1]);
			bqc_pkg::REG_FB1:    prdata = bqc_pkg::PDATA_W'(cfg_q.fb[1]);
			bqc_pkg::REG_FF2:    prdata = bqc_pkg::PDATA_W'(cfg_q.ff[2]);
			bqc_pkg::REG_FB2:    prdata = bqc_pkg::PDATA_W'(cfg_q.fb[2]);
			default:             prdata = '0;
		endcase
	end

endmodule

>>> hw/rtl/bqc_seq.sv
// ----------------------------------------------------------------------------
// bqc_seq
// Microcode sequencer: step counter, section counter and request handshakes.
// ----------------------------------------------------------------------------
module bqc_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [bqc_pkg::SECT_W-1:0]  sections,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic                        out_valid,
	input  logic                        out_ready,
	output bqc_pkg::dp_ctrl_t           ctrl
);

	logic                        busy_q;
	logic                        out_valid_q;
	logic [bqc_pkg::STEP_W-1:0]  step_q;
	logic [bqc_pkg::SECT_W-1:0]  sect_q;
	logic [bqc_pkg::SECT_W-1:0]  n_eff;
	bqc_pkg::uword_t             uw;
	logic                        start;
	logic                        sect_end;
	logic                        last;
	logic                        stall;
	logic                        finish;

	assign uw       = bqc_pkg::ucode(step_q);
	assign start    = in_valid & ~busy_q;
	assign sect_end = busy_q & (uw.seq == bqc_pkg::SEQ_SECT_END);
	assign last     = (sect_q == n_eff - bqc_pkg::SECT_W'(1));
	assign stall    = sect_end & last & out_valid_q & ~out_ready;
	assign finish   = sect_end & last & ~stall;

	always_comb begin
		if (sections == '0)
			n_eff = bqc_pkg::SECT_W'(1);
		else if (sections > bqc_pkg::SECT_W'(bqc_pkg::MAX_SECTIONS))
			n_eff = bqc_pkg::SECT_W'(bqc_pkg::MAX_SECTIONS);
		else
			n_eff = sections;
	end

	assign in_ready  = ~busy_q;
	assign out_valid = out_valid_q;

	assign ctrl.go       = busy_q & ~stall;
	assign ctrl.uw       = uw;
	assign ctrl.sect     = sect_q;
	assign ctrl.load_in  = start;
	assign ctrl.advance  = sect_end & ~last;
	assign ctrl.out_load = finish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			sect_q      <= '0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
				sect_q <= '0;
			end else if (busy_q) begin
				if (uw.seq == bqc_pkg::SEQ_NEXT) begin
					step_q <= step_q + bqc_pkg::STEP_W'(1);
				end else if (!last) begin
					step_q <= '0;
					sect_q <= sect_q + bqc_pkg::SECT_W'(1);
				end else if (finish) begin
					busy_q <= 1'b0;
				end
			end

			if (finish)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

endmodule

>>> hw/rtl/bqc_dp.sv
// ----------------------------------------------------------------------------
// bqc_dp
// Datapath: one 16x16 multiplier, one 32-bit add/subtract, delay state.
// ----------------------------------------------------------------------------
module bqc_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bqc_pkg::cfg_t                       cfg,
	input  bqc_pkg::dp_ctrl_t                   ctrl,
	input  logic signed [bqc_pkg::SAMPLE_W-1:0] sample_in,
	output logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out
);

	logic signed [bqc_pkg::SAMPLE_W-1:0] x_q;
	logic signed [bqc_pkg::SAMPLE_W-1:0] y_q;
	logic signed [bqc_pkg::SAMPLE_W-1:0] out_q;
	logic signed [bqc_pkg::ACC_W-1:0]    p_q;
	logic signed [bqc_pkg::ACC_W-1:0]    acc_q;
	logic [bqc_pkg::MAX_SECTIONS-1:0][bqc_pkg::ACC_W-1:0] s1_q;
	logic [bqc_pkg::MAX_SECTIONS-1:0][bqc_pkg::ACC_W-1:0] s2_q;

	logic [bqc_pkg::FF_W-1:0]            ff;
	logic [bqc_pkg::FB_W-1:0]            fb;
	logic signed [bqc_pkg::COEF_W-1:0]   coef_v;
	logic signed [bqc_pkg::SAMPLE_W-1:0] mul_src;
	logic signed [bqc_pkg::ACC_W-1:0]    prod;
	logic [bqc_pkg::ACC_W-1:0]           opa;
	logic [bqc_pkg::ACC_W-1:0]           opb;
	logic [bqc_pkg::ACC_W-1:0]           sum;

	assign ff = cfg.ff[ctrl.sect];
	assign fb = cfg.fb[ctrl.sect];

	always_comb begin
		case (ctrl.uw.coef)
			bqc_pkg::COEF_B0: coef_v = ff[15:0];
			bqc_pkg::COEF_B1: coef_v = ff[31:16];
			bqc_pkg::COEF_B2: coef_v = ff[47:32];
			bqc_pkg::COEF_A1: coef_v = fb[15:0];
			bqc_pkg::COEF_A2: coef_v = fb[31:16];
			default:          coef_v = '0;
		endcase
	end

	assign mul_src = ctrl.uw.mul_y ? y_q : x_q;
	assign prod    = coef_v * mul_src;

	assign opa = ctrl.uw.opa_acc ? acc_q : p_q;

	always_comb begin
		case (ctrl.uw.opb)
			bqc_pkg::OPB_ZERO: opb = '0;
			bqc_pkg::OPB_S1:   opb = s1_q[ctrl.sect];
			bqc_pkg::OPB_S2:   opb = s2_q[ctrl.sect];
			bqc_pkg::OPB_P:    opb = p_q;
			default:           opb = '0;
		endcase
	end

	assign sum        = ctrl.uw.sub ? (opa - opb) : (opa + opb);
	assign sample_out = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_q <= '0;
			s2_q <= '0;
		end else if (ctrl.go) begin
			case (ctrl.uw.dst)
				bqc_pkg::DST_S1: s1_q[ctrl.sect] <= sum;
				bqc_pkg::DST_S2: s2_q[ctrl.sect] <= sum;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load_in)
			x_q <= sample_in;
		else if (ctrl.advance)
			x_q <= y_q;
		if (ctrl.out_load)
			out_q <= y_q;
		if (ctrl.go) begin
			if (ctrl.uw.mul_en)
				p_q <= prod;
			case (ctrl.uw.dst)
				bqc_pkg::DST_Y:   y_q   <= sum[bqc_pkg::FRAC_BITS +: bqc_pkg::SAMPLE_W];
				bqc_pkg::DST_ACC: acc_q <= sum;
				default: ;
			endcase
		end
	end

endmodule

>>> hw/rtl/biquad_cascade_q15_core.sv
// ----------------------------------------------------------------------------
// biquad_cascade_q15_core
// Cascade of up to three Q15 biquad sections, transposed direct form II.
// ----------------------------------------------------------------------------
// channel  | dir | payload            | handshake
// in_ch    | in  | sample_in  s16     | valid/ready
// out_ch   | out | sample_out s16     | valid/ready, output register
// apb      | in  | 64-bit data, 6-bit | psel/penable, pready tied high
//
// Each section runs the microcode steps through one shared multiplier and
// adder, one section after the other for the n active sections, and the
// next item is accepted in the cycle after the last section finishes.
// Reset at once clears delay state, coefficients and control, sets 2 sections.
// A result waiting in the output register does not block the next accept;
// only finishing an item while the previous result is still held stalls.
// ----------------------------------------------------------------------------
module biquad_cascade_q15_core (
	input  logic                         clk,
	input  logic                         arst_n,
	bqc_in_if.sink                       in_ch,
	bqc_out_if.source                    out_ch,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bqc_pkg::PADDR_W-1:0]  paddr,
	input  logic [bqc_pkg::PDATA_W-1:0]  pwdata,
	output logic [bqc_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);

	bqc_pkg::cfg_t     cfg;
	bqc_pkg::dp_ctrl_t ctrl;

	bqc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	bqc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.sections  (cfg.sections),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.ctrl      (ctrl)
	);

	bqc_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.ctrl       (ctrl),
		.sample_in  (in_ch.sample_in),
		.sample_out (out_ch.sample_out)
	);

endmodule

>>> hw/rtl/bqc_checker.sv
// ----------------------------------------------------------------------------
// bqc_checker
// Port-level checks of the biquad cascade, bound to the top level.
// ----------------------------------------------------------------------------
module bqc_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic signed [bqc_pkg::SAMPLE_W-1:0] sample_out
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped before taken");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sample_out))
		else $error("stalled output payload changed");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while a sample is in flight");

	a_result_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $rose(in_ready))
		else $error("result appeared without the datapath going idle");

endmodule

bind biquad_cascade_q15_core bqc_checker u_bqc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.sample_out (out_ch.sample_out)
);

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Q15 biquad cascade core. A short table of
// register writes and sample requests runs first, then random phases that
// reprogram the section count and all coefficients. A cascade model predicts
// the results the table leaves open, and both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bqc_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASES = 12;
	localparam int PHASE_ITEMS = 100;
	localparam int DRAIN_CYCLES = 6 * MAX_SECTIONS + 2;
	localparam int DIRECTED_ROWS = 33;
	localparam logic [2:0] REG_UNMAPPED = 3'd7;

	typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [2:0]         index;
		logic [63:0]        value;
		logic signed [15:0] sample;
		bit                 typed;
		logic signed [15:0] result;
	} row_t;

	row_t directed_rows [DIRECTED_ROWS] = '{
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh7FFF,   1'b1, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh8000,   1'b1, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh0000,   1'b1, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  -16'sd1,     1'b1, 16'sh0000},
		'{ROW_WRITE,  REG_ACTIVE,   64'h1,                  16'sh0000,   1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FF0,      64'h8000,               16'sh0000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sd1,      1'b1, -16'sd1},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh8000,   1'b1, 16'sh8000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh7FFF,   1'b1, 16'sh8001},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh0000,   1'b1, 16'sh0000},
		'{ROW_WRITE,  REG_ACTIVE,   64'hFFFF_FFFF_FFFF_FFFC, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sd100,    1'b1, -16'sd100},
		'{ROW_WRITE,  REG_UNMAPPED, 64'hFFFF_FFFF_FFFF_FFFF, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sd5,      1'b1, -16'sd5},
		'{ROW_WRITE,  REG_ACTIVE,   64'h5A5A_0000_0000_0003, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FF1,      64'h8000,               16'sh0000,   1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FF2,      64'h8000,               16'sh0000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sd1234,   1'b1, -16'sd1234},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh8000,   1'b1, 16'sh8000},
		'{ROW_WRITE,  REG_FF0,      64'h0000_7FFF_8000_7FFF, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FB0,      64'hA5A5_0000_8000_7FFF, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FF1,      64'h0000_8000_7FFF_4000, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FB1,      64'h0000_0000_7FFF_8000, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FF2,      64'hFFFF_2000_C000_7FFF, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_WRITE,  REG_FB2,      64'h0000_0000_C000_4000, 16'sh0000,  1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh7FFF,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh8000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh7FFF,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh8000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh0000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sh0000,   1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  16'sd1,      1'b0, 16'sh0000},
		'{ROW_SAMPLE, REG_ACTIVE,   64'h0,                  -16'sd1,     1'b0, 16'sh0000}
	};

	logic                clk = 1'b0;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [PADDR_W-1:0]  paddr;
	logic [PDATA_W-1:0]  pwdata;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	logic [1:0]          sections_cfg;
	logic [FF_W-1:0]     ff_cfg [MAX_SECTIONS];
	logic [FB_W-1:0]     fb_cfg [MAX_SECTIONS];
	logic [ACC_W-1:0]    s1_state [MAX_SECTIONS];
	logic [ACC_W-1:0]    s2_state [MAX_SECTIONS];

	logic signed [SAMPLE_W-1:0] expected_samples [$];
	int  failures = 0;
	int  cycle_count = 0;
	bit  in_steady = 1'b0;
	bit  out_steady = 1'b0;

	bqc_in_if  in_ch ();
	bqc_out_if out_ch ();

	biquad_cascade_q15_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #6 clk = ~clk;

	function automatic void store_register(input logic [2:0] index, input logic [63:0] value);
		int sect;
		sect = (int'(index) - 1) / 2;
		if (index == REG_ACTIVE) begin
			sections_cfg = value[1:0];
		end else if (index <= REG_FB2) begin
			if (index[0]) begin
				ff_cfg[sect] = value[FF_W-1:0];
			end else begin
				fb_cfg[sect] = value[FB_W-1:0];
			end
		end
	endfunction

	function automatic logic signed [SAMPLE_W-1:0] biquad_filter(
			input logic signed [SAMPLE_W-1:0] sample);
		logic signed [ACC_W-1:0] x, y, b0, b1, b2, a1, a2;
		logic [ACC_W-1:0]        acc;
		int                      n;
		int                      k;
		n = int'(sections_cfg);
		if (n < 1) n = 1;
		if (n > MAX_SECTIONS) n = MAX_SECTIONS;
		x = sample;
		for (k = 0; k < n; k++) begin
			b0 = $signed(ff_cfg[k][15:0]);
			b1 = $signed(ff_cfg[k][31:16]);
			b2 = $signed(ff_cfg[k][47:32]);
			a1 = $signed(fb_cfg[k][15:0]);
			a2 = $signed(fb_cfg[k][31:16]);
			acc = b0 * x + s1_state[k];
			y = $signed(acc[FRAC_BITS+15:FRAC_BITS]);
			s1_state[k] = b1 * x - a1 * y + s2_state[k];
			s2_state[k] = b2 * x - a2 * y;
			x = y;
		end
		return x[SAMPLE_W-1:0];
	endfunction

	function automatic logic [COEF_W-1:0] random_coef();
		logic [31:0]       r;
		logic [COEF_W-1:0] c;
		r = $urandom;
		case ($urandom_range(0, 4))
			0: c = r[0] ? 16'h7FFF : 16'h8000;
			1: c = 16'h0000;
			2: c = {{5{r[10]}}, r[10:0]};
			default: c = r[15:0];
		endcase
		return c;
	endfunction

	task automatic write_register(input logic [2:0] index, input logic [63:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {index, 3'b000};
		pwdata <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		store_register(index, value);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_ch.valid <= 1'b0;
		while (expected_samples.size() != 0) @(negedge clk);
	endtask

	task automatic send_sample(input logic signed [SAMPLE_W-1:0] sample, input bit typed,
			input logic signed [SAMPLE_W-1:0] result);
		int                         gap;
		logic signed [SAMPLE_W-1:0] predicted;
		if ($urandom_range(0, 39) == 0) in_steady = !in_steady;
		gap = in_steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample_in <= sample;
		do @(posedge clk); while (in_ch.ready !== 1'b1);
		predicted = biquad_filter(sample);
		expected_samples.push_back(typed ? result : predicted);
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	always @(posedge clk) begin : result_check
		logic signed [SAMPLE_W-1:0] expected;
		if (arst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
			if (expected_samples.size() == 0) begin
				$error("sample_out: expected none, actual %0d", out_ch.sample_out);
				failures++;
			end else begin
				expected = expected_samples.pop_front();
				if (out_ch.sample_out !== expected) begin
					$error("sample_out: expected %0d, actual %0d", expected, out_ch.sample_out);
					failures++;
				end
			end
		end
	end

	initial begin : result_sink
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 39) == 0) out_steady = !out_steady;
			stall = out_steady ? 0 : $urandom_range(0, 9);
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (out_ch.valid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin : stimulus
		logic [63:0]                word;
		logic signed [SAMPLE_W-1:0] sample;
		int                         sect;
		in_ch.valid = 1'b0;
		in_ch.sample_in = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		sections_cfg = 2'd2;
		for (sect = 0; sect < MAX_SECTIONS; sect++) begin
			ff_cfg[sect] = '0;
			fb_cfg[sect] = '0;
			s1_state[sect] = '0;
			s2_state[sect] = '0;
		end
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_register(directed_rows[i].index, directed_rows[i].value);
			end else begin
				send_sample(directed_rows[i].sample, directed_rows[i].typed,
					directed_rows[i].result);
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			wait_idle();
			word = {$urandom, $urandom};
			word[1:0] = (phase < 4) ? 2'(phase) : 2'($urandom_range(0, 3));
			write_register(REG_ACTIVE, word);
			for (sect = 0; sect < MAX_SECTIONS; sect++) begin
				word = {$urandom, $urandom};
				word[FF_W-1:0] = {random_coef(), random_coef(), random_coef()};
				write_register(3'(REG_FF0 + 2 * sect), word);
				word = {$urandom, $urandom};
				word[FB_W-1:0] = {random_coef(), random_coef()};
				write_register(3'(REG_FB0 + 2 * sect), word);
			end
			if (phase % 3 == 0) write_register(REG_UNMAPPED, {$urandom, $urandom});
			repeat (PHASE_ITEMS) begin
				if ($urandom_range(0, 15) == 0) begin
					sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				end else begin
					sample = 16'($urandom);
				end
				send_sample(sample, 1'b0, '0);
			end
		end

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
